// File: rtl/present24_encrypt_core_macros.svh
// Assertion macros used by the present24 encrypt core checker.
`ifndef PRESENT24_ENCRYPT_CORE_MACROS_SVH
`define PRESENT24_ENCRYPT_CORE_MACROS_SVH

// Concurrent assertion on the rising clock, suspended while reset is asserted.
`define PRES24_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion on the rising clock that is also checked through reset.
`define PRES24_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/pres24_pkg.sv
// Package with constants and round functions of the 24-bit PRESENT encrypt core.
`timescale 1ns / 1ps

package pres24_pkg;

  localparam int DATA_W         = 24;
  localparam int SLOT_W         = 4;
  localparam int NUM_ROUNDS_DEF = 10;
  localparam int IN_TDATA_W     = 32;
  localparam int OUT_TDATA_W    = 24;

  typedef enum logic {
    CMD_LOAD    = 1'b0,
    CMD_ENCRYPT = 1'b1
  } cmd_t;

  typedef logic [DATA_W-1:0] block_t;

  localparam logic [3:0] SBOX [16] = '{
    4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
    4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
  };

  // Substitution of all six nibbles.
  function automatic block_t sub_layer(input block_t x);
    block_t y;
    y = '0;
    for (int n = 0; n < DATA_W / 4; n++) begin
      y[4*n +: 4] = SBOX[x[4*n +: 4]];
    end
    return y;
  endfunction

  // Bit j moves to 6*(j mod 4) + (j div 4); pure wiring.
  function automatic block_t perm_layer(input block_t x);
    block_t y;
    y = '0;
    for (int j = 0; j < DATA_W; j++) begin
      y[6 * (j % 4) + (j / 4)] = x[j];
    end
    return y;
  endfunction

  function automatic block_t round_fn(input block_t x, input block_t key);
    return perm_layer(sub_layer(x ^ key));
  endfunction

endpackage

// File: rtl/present24_encrypt_core.sv
// Top level of the 24-bit PRESENT encrypt core: key table, round logic and stream ports.
`timescale 1ns / 1ps
// An encrypt's ciphertext reaches out_tvalid via the input register, then the result register.
// Throughput: one transaction per cycle; all NUM_ROUNDS rounds sit between the input register
// and the result register, so a stalled result holds the input register and then in_tready.
// Loads write key slots 0..NUM_ROUNDS at the accepting edge and never produce a result.
// Reset (rst_n low, synchronous) empties both registers; the key table is not reset.

module present24_encrypt_core #(
  parameter int NUM_ROUNDS = pres24_pkg::NUM_ROUNDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [3:0] key_slot, [27:4] data_word, [31:28] zero
  input  logic [pres24_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [23:0] ciphertext
  output logic [pres24_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int DEPTH = NUM_ROUNDS + 1;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CMP_W = pres24_pkg::SLOT_W + IDX_W;

  logic                         in_acc;
  logic [pres24_pkg::SLOT_W-1:0] in_slot;
  pres24_pkg::block_t           in_word;
  logic [CMP_W-1:0]             slot_ext;
  logic                         key_we;

  logic                         s1_valid_r, s1_valid_nxt;
  pres24_pkg::block_t           s1_data_r;
  logic                         s1_move;

  logic                         out_valid_r, out_valid_nxt;
  pres24_pkg::block_t           out_data_r;

  pres24_pkg::block_t           keys_r [DEPTH];
  pres24_pkg::block_t           st [DEPTH];
  pres24_pkg::block_t           cipher;

  assign in_slot  = in_tdata[pres24_pkg::SLOT_W-1:0];
  assign in_word  = in_tdata[pres24_pkg::SLOT_W +: pres24_pkg::DATA_W];
  assign slot_ext = CMP_W'(in_slot);

  // The input register advances only when the result register can take its value,
  // so a key load never changes the table under a waiting encrypt.
  assign s1_move   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_move;
  assign in_acc    = in_tvalid && in_tready;
  assign key_we    = in_acc && (in_tuser == pres24_pkg::CMD_LOAD) &&
                     (slot_ext <= CMP_W'(NUM_ROUNDS));

  always_comb begin
    s1_valid_nxt = s1_valid_r && !s1_move;
    if (in_acc && (in_tuser == pres24_pkg::CMD_ENCRYPT)) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == pres24_pkg::CMD_ENCRYPT)) begin
      s1_data_r <= in_word;
    end
    if (s1_move) begin
      out_data_r <= cipher;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      keys_r[slot_ext[IDX_W-1:0]] <= in_word;
    end
  end

  assign st[0] = s1_data_r;

  for (genvar r = 0; r < NUM_ROUNDS; r++) begin : g_round
    assign st[r+1] = pres24_pkg::round_fn(st[r], keys_r[r]);
  end

  assign cipher = st[NUM_ROUNDS] ^ keys_r[NUM_ROUNDS];

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: rtl/pres24_checker.sv
// Port-level checker for the present24 encrypt core, bound to the top level.
`timescale 1ns / 1ps
`include "present24_encrypt_core_macros.svh"

module pres24_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_tvalid,
  input logic                               in_tready,
  input logic                               in_tuser,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [pres24_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic enc_acc;
  logic out_stall;
  logic no_enc_idle;

  assign enc_acc     = in_tvalid && in_tready && (in_tuser == pres24_pkg::CMD_ENCRYPT);
  assign out_stall   = out_tvalid && !out_tready;
  assign no_enc_idle = !enc_acc && !out_tvalid;

  // A result waiting to be taken keeps its value.
  `PRES24_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_tdata), "stalled result changed")

  // Reset leaves no result on the output.
  `PRES24_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // With the output empty, the input side is never stalled.
  `PRES24_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready, "input stalled with empty output")

  // A result only follows an accepted encrypt transaction; loads produce nothing.
  `PRES24_ASSERT(a_no_phantom, !enc_acc ##1 no_enc_idle |=> !out_tvalid, "result without encrypt")

endmodule

bind present24_encrypt_core pres24_checker u_pres24_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
